@@ hw/rtl/grt_pkg.sv @@
// ----------------------------------------------------------------------------
// grt_pkg
// shared types and constants of the grind timer controller
// ----------------------------------------------------------------------------
package grt_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 4;

   localparam logic [1:0] MODE_SLEEP = 2'd0;
   localparam logic [1:0] MODE_SET   = 2'd1;
   localparam logic [1:0] MODE_RUN   = 2'd2;
   localparam logic [1:0] MODE_DONE  = 2'd3;

   localparam logic [1:0] REG_IDLE_TIMEOUT = 2'd0;
   localparam logic [1:0] REG_MAX_SECONDS  = 2'd1;
   localparam logic [1:0] REG_DEFAULT_SECS = 2'd2;
   localparam logic [1:0] REG_RESTART_MS   = 2'd3;

   localparam logic [7:0]  IDLE_TIMEOUT_RESET = 8'd15;
   localparam logic [5:0]  MAX_SECONDS_RESET  = 6'd60;
   localparam logic [5:0]  DEFAULT_SECS_RESET = 6'd10;
   localparam logic [31:0] RESTART_MS_RESET   = 32'h8000_0000;
   localparam logic [17:0] MS_PER_SECOND      = 18'd1000;
   localparam logic [17:0] IDLE_LOAD_RESET    = 18'd15000;
   localparam logic [9:0]  LAST_MS            = 10'd999;

   typedef struct packed {
      logic [17:0] idle_load_ms;
      logic [5:0]  max_seconds;
      logic [31:0] restart_after_ms;
   } config_type;

   typedef struct packed {
      logic       motor_on;
      logic [1:0] mode_now;
      logic [5:0] chosen_seconds;
      logic [5:0] seconds_left;
      logic       save_strobe;
      logic       restart_strobe;
   } result_type;

endpackage

@@ hw/rtl/grind_timer_controller.sv @@
// ----------------------------------------------------------------------------
// grind_timer_controller
// appliance run timer, one item per millisecond tick
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid / req_ready  turn_right, turn_left, press
//  rsp       out        rsp_valid / rsp_ready  motor_on, mode_now, chosen_seconds,
//                                              seconds_left, save_strobe,
//                                              restart_strobe
//  csr       in/out     psel, penable, pwrite  paddr, pwdata, prdata, pready
//
//  one item per cycle while the queue has room; the result is in the queue in the
//  cycle after acceptance. tick state is updated combinationally between state and result registers
//  a two-entry result queue lets items in while a result waits
//  req_ready drops only when both queue entries are occupied
//  synchronous reset, no clearing pass
// ----------------------------------------------------------------------------
module grind_timer_controller
   import grt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_turn_right,
   input  logic                      req_turn_left,
   input  logic                      req_press,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_motor_on,
   output logic [1:0]                rsp_mode_now,
   output logic [5:0]                rsp_chosen_seconds,
   output logic [5:0]                rsp_seconds_left,
   output logic                      rsp_save_strobe,
   output logic                      rsp_restart_strobe,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   config_type cfg;
   result_type tick_result;
   result_type rsp_data;
   logic       tick;

   assign tick = req_valid & req_ready;

   grt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   grt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .turn_right (req_turn_right),
      .turn_left  (req_turn_left),
      .press      (req_press),
      .cfg        (cfg),
      .result     (tick_result)
   );

   grt_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (tick),
      .push_data (tick_result),
      .has_room  (req_ready),
      .pop_valid (rsp_valid),
      .pop_ready (rsp_ready),
      .pop_data  (rsp_data)
   );

   assign rsp_motor_on       = rsp_data.motor_on;
   assign rsp_mode_now       = rsp_data.mode_now;
   assign rsp_chosen_seconds = rsp_data.chosen_seconds;
   assign rsp_seconds_left   = rsp_data.seconds_left;
   assign rsp_save_strobe    = rsp_data.save_strobe;
   assign rsp_restart_strobe = rsp_data.restart_strobe;

endmodule

@@ hw/rtl/grt_csr.sv @@
// ----------------------------------------------------------------------------
// grt_csr
// configuration registers with apb-style write and read access
// ----------------------------------------------------------------------------
module grt_csr
   import grt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready,
   output config_type                cfg
);

   logic [7:0]  idle_timeout_ff;
   logic [5:0]  max_seconds_ff;
   logic [5:0]  default_secs_ff;
   logic [31:0] restart_ms_ff;
   logic [17:0] idle_load_ff;
   logic [17:0] idle_load_in;
   logic [1:0]  reg_index;
   logic        wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign wr_en     = psel & penable & pwrite;

   // timeout in ms, kept ready for the countdown
   assign idle_load_in = {10'd0, pwdata[7:0]} * MS_PER_SECOND;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff <= IDLE_TIMEOUT_RESET;
         max_seconds_ff  <= MAX_SECONDS_RESET;
         default_secs_ff <= DEFAULT_SECS_RESET;
         restart_ms_ff   <= RESTART_MS_RESET;
         idle_load_ff    <= IDLE_LOAD_RESET;
      end else if (wr_en) begin
         unique case (reg_index)
            REG_IDLE_TIMEOUT: begin
               idle_timeout_ff <= pwdata[7:0];
               idle_load_ff    <= idle_load_in;
            end
            REG_MAX_SECONDS:  max_seconds_ff  <= pwdata[5:0];
            REG_DEFAULT_SECS: default_secs_ff <= pwdata[5:0];
            REG_RESTART_MS:   restart_ms_ff   <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_IDLE_TIMEOUT: prdata = {24'd0, idle_timeout_ff};
         REG_MAX_SECONDS:  prdata = {26'd0, max_seconds_ff};
         REG_DEFAULT_SECS: prdata = {26'd0, default_secs_ff};
         REG_RESTART_MS:   prdata = restart_ms_ff;
         default:          prdata = 32'd0;
      endcase
   end

   assign cfg.idle_load_ms     = idle_load_ff;
   assign cfg.max_seconds      = max_seconds_ff;
   assign cfg.restart_after_ms = restart_ms_ff;

endmodule

@@ hw/rtl/grt_core.sv @@
// ----------------------------------------------------------------------------
// grt_core
// per-tick mode, countdown and setting update
// ----------------------------------------------------------------------------
module grt_core
   import grt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       tick,
   input  logic       turn_right,
   input  logic       turn_left,
   input  logic       press,
   input  config_type cfg,
   output result_type result
);

   logic [1:0]  mode_ff, mode_in;
   logic [5:0]  sel_ff, sel_in;
   logic [5:0]  rem_ff, rem_in;
   logic [17:0] idle_ff, idle_in;
   logic [5:0]  run_sec_ff, run_sec_in;
   logic [9:0]  run_ms_ff, run_ms_in;
   logic        armed_ff, armed_in;
   logic [31:0] uptime_ff, uptime_in;

   logic        event_seen;
   logic        idle_exp;
   logic        run_exp;
   logic        save;
   logic        restart;
   logic [5:0]  top;
   logic [5:0]  base;
   logic [6:0]  stepped;
   logic [5:0]  clamped;

   assign event_seen = turn_right | turn_left | press;
   assign top        = (cfg.max_seconds == 6'd0) ? 6'd1 : cfg.max_seconds;
   assign base       = (sel_ff == 6'd0) ? rem_ff : sel_ff;

   always_comb begin
      if (turn_right) begin
         stepped = {1'b0, base} + 7'd1;
      end else if (turn_left) begin
         stepped = (base == 6'd0) ? 7'd0 : {1'b0, base} - 7'd1;
      end else begin
         stepped = {1'b0, base};
      end
      if (stepped == 7'd0) begin
         clamped = 6'd1;
      end else if (stepped > {1'b0, top}) begin
         clamped = top;
      end else begin
         clamped = stepped[5:0];
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      sel_in     = sel_ff;
      rem_in     = rem_ff;
      idle_in    = idle_ff;
      run_sec_in = run_sec_ff;
      run_ms_in  = run_ms_ff;
      armed_in   = armed_ff;
      uptime_in  = uptime_ff + 32'd1;
      idle_exp   = 1'b0;
      run_exp    = 1'b0;
      save       = 1'b0;
      restart    = 1'b0;

      // inactivity countdown
      if (event_seen) begin
         idle_in = cfg.idle_load_ms;
      end else if (idle_ff == 18'd0) begin
         idle_exp = 1'b1;
      end else begin
         idle_in = idle_ff - 18'd1;
      end
      if (idle_exp) begin
         mode_in = MODE_SLEEP;
      end

      // run countdown kept as seconds and ms within the second
      if (armed_ff) begin
         if (run_sec_ff == 6'd0 && run_ms_ff == 10'd0) begin
            run_exp = 1'b1;
         end else if (run_ms_ff == 10'd0) begin
            run_sec_in = run_sec_ff - 6'd1;
            run_ms_in  = LAST_MS;
         end else begin
            run_ms_in = run_ms_ff - 10'd1;
         end
      end

      unique case (mode_in)
         MODE_SLEEP: begin
            if (event_seen) begin
               mode_in = MODE_SET;
            end else if (uptime_ff > cfg.restart_after_ms) begin
               restart    = 1'b1;
               mode_in    = MODE_SLEEP;
               sel_in     = 6'd0;
               idle_in    = 18'd0;
               run_sec_in = 6'd0;
               run_ms_in  = 10'd0;
               armed_in   = 1'b0;
               uptime_in  = 32'd0;
            end
         end
         MODE_SET: begin
            sel_in = clamped;
            if (press) begin
               save    = (rem_ff != clamped);
               rem_in  = clamped;
               mode_in = MODE_RUN;
            end
         end
         MODE_RUN: begin
            idle_in = cfg.idle_load_ms;
            if (press) begin
               mode_in = MODE_DONE;
            end
            if (!armed_ff) begin
               armed_in   = 1'b1;
               run_sec_in = sel_ff;
               run_ms_in  = 10'd0;
            end else if (run_exp) begin
               mode_in = MODE_DONE;
            end
         end
         MODE_DONE: begin
            armed_in   = 1'b0;
            run_sec_in = 6'd0;
            run_ms_in  = 10'd0;
            if (event_seen) begin
               mode_in = MODE_SET;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_SLEEP;
         sel_ff     <= 6'd0;
         rem_ff     <= DEFAULT_SECS_RESET;
         idle_ff    <= 18'd0;
         run_sec_ff <= 6'd0;
         run_ms_ff  <= 10'd0;
         armed_ff   <= 1'b0;
         uptime_ff  <= 32'd0;
      end else if (tick) begin
         mode_ff    <= mode_in;
         sel_ff     <= sel_in;
         rem_ff     <= rem_in;
         idle_ff    <= idle_in;
         run_sec_ff <= run_sec_in;
         run_ms_ff  <= run_ms_in;
         armed_ff   <= armed_in;
         uptime_ff  <= uptime_in;
      end
   end

   assign result.motor_on       = (mode_in == MODE_RUN);
   assign result.mode_now       = mode_in;
   assign result.chosen_seconds = sel_in;
   assign result.seconds_left   = (mode_in == MODE_RUN && armed_in) ? run_sec_in : 6'd0;
   assign result.save_strobe    = save;
   assign result.restart_strobe = restart;

endmodule

@@ hw/rtl/grt_out_buf.sv @@
// ----------------------------------------------------------------------------
// grt_out_buf
// two-entry result queue between the tick logic and the result channel
// ----------------------------------------------------------------------------
module grt_out_buf
   import grt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       has_room,
   output logic       pop_valid,
   input  logic       pop_ready,
   output result_type pop_data
);

   result_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign has_room  = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop       = pop_valid & pop_ready;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ verif/tb_grind_timer_controller.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grind_timer_controller
// self-checking bench for the grind timer controller
// ----------------------------------------------------------------------------
// a short directed table walks wake-up, stepping, clamping, save, run, stop,
// zero idle timeout, zero max seconds and soft restart; then random knob and
// button sessions run under four register settings and four handshake mixes.
// every result item is checked against the row's expected value, if the row gives
// one, else against a tick-level model of the timer kept alongside the block.
// ----------------------------------------------------------------------------
module tb_grind_timer_controller;
   import grt_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_TICKS  = 100;
   localparam int REPORT_LIMIT = 10;
   localparam result_type ANY  = '0;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [1:0]   csr_index;
      logic [31:0]  value;
      logic         right;
      logic         left;
      logic         press;
      bit           typed;
      result_type   want;
   } script_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_turn_right = 1'b0;
   logic                      req_turn_left = 1'b0;
   logic                      req_press = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_motor_on;
   logic [1:0]                rsp_mode_now;
   logic [5:0]                rsp_chosen_seconds;
   logic [5:0]                rsp_seconds_left;
   logic                      rsp_save_strobe;
   logic                      rsp_restart_strobe;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [31:0]               pwdata = '0;
   logic [31:0]               prdata;
   logic                      pready;

   // register copies
   logic [7:0]  cfg_idle_s = IDLE_TIMEOUT_RESET;
   logic [5:0]  cfg_max_s = MAX_SECONDS_RESET;
   logic [5:0]  cfg_default_s = DEFAULT_SECS_RESET;
   logic [31:0] cfg_restart_ms = RESTART_MS_RESET;

   // timer state
   logic [1:0]  tick_mode = MODE_SLEEP;
   logic [5:0]  sel_secs = '0;
   logic [5:0]  kept_secs = DEFAULT_SECS_RESET;
   logic [17:0] idle_ms = '0;
   logic [15:0] run_ms = '0;
   logic        run_live = 1'b0;
   logic [31:0] up_ms = '0;

   result_type     pending_readouts[$];
   script_row_type script[$];
   int             readout_errors = 0;
   int             idle_pct = 0;
   int             stall_pct = 0;
   int             phase_ticks = 0;
   int             cycle_count;

   grind_timer_controller dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_turn_right     (req_turn_right),
      .req_turn_left      (req_turn_left),
      .req_press          (req_press),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_motor_on       (rsp_motor_on),
      .rsp_mode_now       (rsp_mode_now),
      .rsp_chosen_seconds (rsp_chosen_seconds),
      .rsp_seconds_left   (rsp_seconds_left),
      .rsp_save_strobe    (rsp_save_strobe),
      .rsp_restart_strobe (rsp_restart_strobe),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic string item_text(input result_type r);
      return $sformatf("motor %0d mode %0d chosen %0d left %0d save %0d restart %0d",
                       r.motor_on, r.mode_now, r.chosen_seconds, r.seconds_left,
                       r.save_strobe, r.restart_strobe);
   endfunction

   // one millisecond tick of the timer
   function automatic result_type advance_tick(input logic right, input logic left,
                                               input logic press);
      logic        any_event;
      int unsigned idle_load;
      int unsigned run_load;
      int unsigned secs;
      int          top;
      int          v;
      logic        idle_out;
      logic        run_out;
      logic        saved;
      logic        restarted;
      result_type  o;
      any_event = right | left | press;
      idle_load = cfg_idle_s * 1000;
      top = (cfg_max_s == 0) ? 1 : cfg_max_s;
      idle_out = 1'b0;
      run_out = 1'b0;
      saved = 1'b0;
      restarted = 1'b0;
      if (any_event) begin
         idle_ms = idle_load[17:0];
      end else if (idle_ms == 0) begin
         idle_out = 1'b1;
      end else begin
         idle_ms = idle_ms - 1'b1;
      end
      if (idle_out) tick_mode = MODE_SLEEP;
      if (run_live) begin
         if (run_ms == 0) run_out = 1'b1;
         else run_ms = run_ms - 1'b1;
      end
      case (tick_mode)
         MODE_SLEEP: begin
            if (any_event) begin
               tick_mode = MODE_SET;
            end else if (up_ms > cfg_restart_ms) begin
               sel_secs = '0;
               idle_ms = '0;
               run_ms = '0;
               run_live = 1'b0;
               up_ms = '0;
               restarted = 1'b1;
            end
         end
         MODE_SET: begin
            if (sel_secs == 0) sel_secs = kept_secs;
            v = sel_secs;
            if (right) v = v + 1;
            else if (left) v = v - 1;
            if (v < 1) v = 1;
            else if (v > top) v = top;
            sel_secs = v[5:0];
            if (press) begin
               saved = (kept_secs != sel_secs);
               kept_secs = sel_secs;
               tick_mode = MODE_RUN;
            end
         end
         MODE_RUN: begin
            idle_ms = idle_load[17:0];
            if (press) tick_mode = MODE_DONE;
            if (!run_live) begin
               run_live = 1'b1;
               run_load = sel_secs * 1000;
               run_ms = run_load[15:0];
               run_out = 1'b0;
            end
            if (run_out) tick_mode = MODE_DONE;
         end
         default: begin
            run_live = 1'b0;
            run_ms = '0;
            if (any_event) tick_mode = MODE_SET;
         end
      endcase
      if (!restarted) up_ms = up_ms + 1'b1;
      secs = run_ms / 1000;
      o.motor_on = (tick_mode == MODE_RUN);
      o.mode_now = tick_mode;
      o.chosen_seconds = sel_secs;
      o.seconds_left = (tick_mode == MODE_RUN && run_live) ? secs[5:0] : 6'd0;
      o.save_strobe = saved;
      o.restart_strobe = restarted;
      return o;
   endfunction

   task automatic add_tick(input logic right, input logic left, input logic press,
                           input bit typed, input result_type want);
      script_row_type row;
      row.kind = ROW_TICK;
      row.csr_index = '0;
      row.value = '0;
      row.right = right;
      row.left = left;
      row.press = press;
      row.typed = typed;
      row.want = want;
      script.push_back(row);
   endtask

   task automatic add_write(input logic [1:0] idx, input logic [31:0] value);
      script_row_type row;
      row.kind = ROW_WRITE;
      row.csr_index = idx;
      row.value = value;
      row.right = 1'b0;
      row.left = 1'b0;
      row.press = 1'b0;
      row.typed = 1'b0;
      row.want = ANY;
      script.push_back(row);
   endtask

   task automatic send_tick(input logic right, input logic left, input logic press,
                            input bit typed, input result_type want);
      result_type forecast;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_turn_right <= right;
      req_turn_left <= left;
      req_press <= press;
      do @(posedge clock); while (!req_ready);
      forecast = advance_tick(right, left, press);
      pending_readouts.push_back(typed ? want : forecast);
      phase_ticks++;
   endtask

   task automatic quiet_ticks(input int count);
      repeat (count) send_tick(1'b0, 1'b0, 1'b0, 1'b0, ANY);
   endtask

   // register writes only once every item has come back
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_readouts.size() != 0);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_IDLE_TIMEOUT: cfg_idle_s = value[7:0];
         REG_MAX_SECONDS:  cfg_max_s = value[5:0];
         REG_DEFAULT_SECS: cfg_default_s = value[5:0];
         default:          cfg_restart_ms = value;
      endcase
   endtask

   // wake, step the knob, save, let the timer run a while, maybe stop it
   task automatic random_session();
      int turns;
      int dwell;
      int i;
      logic cw;
      turns = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 6);
      for (i = 0; i < turns; i++) begin
         cw = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 4) == 0) send_tick(1'b0, 1'b0, 1'b0, 1'b0, ANY);
         else send_tick(cw, !cw, 1'b0, 1'b0, ANY);
      end
      cw = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) send_tick(cw, !cw, 1'b1, 1'b0, ANY);
      else send_tick(1'b0, 1'b0, 1'b1, 1'b0, ANY);
      dwell = $urandom_range(0, 25);
      for (i = 0; i < dwell; i++) begin
         cw = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 5) == 0) send_tick(cw, !cw, 1'b0, 1'b0, ANY);
         else send_tick(1'b0, 1'b0, 1'b0, 1'b0, ANY);
      end
      if ($urandom_range(0, 1) == 0) send_tick(1'b0, 1'b0, 1'b1, 1'b0, ANY);
   endtask

   // result side: random stalls and checking
   always @(posedge clock) begin
      result_type got;
      result_type want;
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_motor_on, rsp_mode_now, rsp_chosen_seconds, rsp_seconds_left,
                rsp_save_strobe, rsp_restart_strobe};
         if (pending_readouts.size() == 0) begin
            readout_errors++;
            if (readout_errors <= REPORT_LIMIT)
               $display("unexpected item: %s", item_text(got));
         end else begin
            want = pending_readouts.pop_front();
            if (got !== want) begin
               readout_errors++;
               if (readout_errors <= REPORT_LIMIT) begin
                  $display("mismatch expected: %s", item_text(want));
                  $display("         actual:   %s", item_text(got));
               end
            end
         end
      end
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int             phase;
      int             pick;
      int             long_left;
      int             k;
      logic [2:0]     bits;
      logic [7:0]     s_idle;
      logic [5:0]     s_max;
      logic [5:0]     s_def;
      logic [31:0]    s_restart;
      script_row_type row;

      // wake, step, save and run from the reset settings
      add_tick(1'b0, 1'b0, 1'b0, 1'b1, {1'b0, MODE_SLEEP, 6'd0, 6'd0, 1'b0, 1'b0});
      add_tick(1'b1, 1'b0, 1'b0, 1'b1, {1'b0, MODE_SET, 6'd0, 6'd0, 1'b0, 1'b0});
      add_tick(1'b1, 1'b0, 1'b0, 1'b1, {1'b0, MODE_SET, 6'd11, 6'd0, 1'b0, 1'b0});
      add_tick(1'b0, 1'b1, 1'b0, 1'b1, {1'b0, MODE_SET, 6'd10, 6'd0, 1'b0, 1'b0});
      add_tick(1'b1, 1'b1, 1'b0, 1'b0, ANY);
      add_tick(1'b0, 1'b0, 1'b1, 1'b1, {1'b1, MODE_RUN, 6'd11, 6'd0, 1'b1, 1'b0});
      add_tick(1'b0, 1'b0, 1'b0, 1'b1, {1'b1, MODE_RUN, 6'd11, 6'd11, 1'b0, 1'b0});
      add_tick(1'b0, 1'b0, 1'b0, 1'b0, ANY);
      add_tick(1'b0, 1'b0, 1'b1, 1'b1, {1'b0, MODE_DONE, 6'd11, 6'd0, 1'b0, 1'b0});
      add_tick(1'b0, 1'b0, 1'b0, 1'b0, ANY);
      add_tick(1'b0, 1'b1, 1'b0, 1'b0, ANY);
      add_tick(1'b1, 1'b0, 1'b1, 1'b0, ANY);
      add_tick(1'b0, 1'b0, 1'b1, 1'b0, ANY);
      add_tick(1'b0, 1'b0, 1'b1, 1'b0, ANY);
      add_tick(1'b0, 1'b0, 1'b1, 1'b0, ANY);
      add_tick(1'b0, 1'b1, 1'b0, 1'b0, ANY);
      add_tick(1'b0, 1'b0, 1'b1, 1'b0, ANY);
      // zero max seconds clamps the loaded setting to one
      add_write(REG_MAX_SECONDS, 32'd0);
      add_tick(1'b1, 1'b0, 1'b0, 1'b0, ANY);
      add_tick(1'b0, 1'b0, 1'b0, 1'b0, ANY);
      add_tick(1'b1, 1'b0, 1'b0, 1'b0, ANY);
      // zero idle timeout drops back to sleep on the first quiet tick
      add_write(REG_IDLE_TIMEOUT, 32'd0);
      add_tick(1'b1, 1'b1, 1'b1, 1'b0, ANY);
      add_tick(1'b0, 1'b0, 1'b0, 1'b0, ANY);
      // zero restart limit restarts a quiet sleeping block
      add_write(REG_RESTART_MS, 32'd0);
      add_tick(1'b0, 1'b0, 1'b0, 1'b1, {1'b0, MODE_SLEEP, 6'd0, 6'd0, 1'b0, 1'b1});
      add_tick(1'b0, 1'b0, 1'b0, 1'b1, {1'b0, MODE_SLEEP, 6'd0, 6'd0, 1'b0, 1'b0});
      add_write(REG_DEFAULT_SECS, 32'd1);
      add_tick(1'b0, 1'b1, 1'b0, 1'b0, ANY);
      add_tick(1'b0, 1'b0, 1'b0, 1'b0, ANY);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < script.size(); k++) begin
         row = script[k];
         if (row.kind == ROW_WRITE) csr_write(row.csr_index, row.value);
         else send_tick(row.right, row.left, row.press, row.typed, row.want);
      end

      // one long quiet stretch over the whole random part
      long_left = 1;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               s_idle = 8'd0;   s_max = 6'd63; s_def = 6'd0;  s_restart = 32'hFFFF_FFFF;
            end
            1: begin
               s_idle = 8'd1;   s_max = 6'd1;  s_def = 6'd60; s_restart = 32'd1;
            end
            2: begin
               s_idle = 8'd255; s_max = 6'd60; s_def = 6'd63; s_restart = 32'h8000_0000;
            end
            default: begin
               s_idle = 8'd2;   s_max = 6'd5;  s_def = 6'd1;  s_restart = 32'd50;
            end
         endcase
         csr_write(REG_IDLE_TIMEOUT, {24'd0, s_idle});
         csr_write(REG_MAX_SECONDS, {26'd0, s_max});
         csr_write(REG_DEFAULT_SECS, {26'd0, s_def});
         csr_write(REG_RESTART_MS, s_restart);
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 86; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 86; end
            default: begin idle_pct = 6;  stall_pct = 6;  end
         endcase
         phase_ticks = 0;
         while (phase_ticks < PHASE_TICKS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               random_session();
            end else if (pick < 70) begin
               bits = 3'($urandom_range(0, 7));
               send_tick(bits[0], bits[1], bits[2], 1'b0, ANY);
            end else if (pick < 92 || long_left == 0) begin
               quiet_ticks($urandom_range(1, 40));
            end else begin
               // long enough for a one second run or idle timeout to run out
               long_left--;
               quiet_ticks($urandom_range(1000, 1100));
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_readouts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (readout_errors == 0 && pending_readouts.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
